// ===== sv/refcounted_page_packet_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Shorthand for the concurrent checks at the end of the allocator top level.
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_PACKET_ALLOCATOR_CORE_ASSERT_SVH
`define REFCOUNTED_PAGE_PACKET_ALLOCATOR_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define RPPA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("allocator invariant violated");

// Same-cycle implication
`define RPPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator implication violated");

// Next-cycle implication
`define RPPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator sequence violated");

`endif

// ===== sv/rppa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator package
// Shared constants, request/status codes and adder opcodes.
// ----------------------------------------------------------------------------
package rppa_pkg;

  // Default sizing
  localparam int MAX_PAGES_DEF    = 16;
  localparam int PAGE_SLOTS_DEF   = 10;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int COUNT_BITS_DEF   = 16;

  // Fixed field widths
  localparam int CFG_W    = 13;
  localparam int MODE_W   = 2;
  localparam int SIZE_W   = 12;
  localparam int PAGE_W   = 4;
  localparam int STATUS_W = 3;
  localparam int OFF_W    = 16;
  localparam int LEN_W    = 12;
  localparam int OCNT_W   = 16;

  // Packet size limits
  localparam int MAX_PKT       = 4096;
  localparam int MAX_PKT_RESET = 256;

  // Request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RETAIN  = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOPAGE   = 3'd2,
    ST_OVERSIZE = 3'd3,
    ST_SAT      = 3'd4,
    ST_UNDER    = 3'd5
  } status_t;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ===== sv/rppa_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator shared adder
// One add/subtract unit used for count updates, fill pointer advance and
// the page threshold compare.
// ----------------------------------------------------------------------------
module rppa_alu
  import rppa_pkg::*;
#(
  parameter int W = 17
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   sum,
  output logic           a_ge_b   // valid for ALU_SUB
);

  logic [W:0] full;
  logic [W-1:0] b_in;

  // Subtract as a + ~b + 1; carry out means no borrow
  assign b_in   = (op == ALU_SUB) ? ~b : b;
  assign full   = {1'b0, a} + {1'b0, b_in} + {{W{1'b0}}, (op == ALU_SUB)};
  assign sum    = full[W-1:0];
  assign a_ge_b = full[W];

endmodule

// ===== sv/rppa_refmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator reference count store
// Count memory with registered read, a zero flag per page in flops, and the
// lowest-free-page pick over the opened pages.
// ----------------------------------------------------------------------------
module rppa_refmem
  import rppa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
  localparam int OPN_W = $clog2(MAX_PAGES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [PG_W-1:0]       rd_addr,
  output logic [COUNT_BITS-1:0] rd_cnt,
  input  logic                  wr_en,
  input  logic [PG_W-1:0]       wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  input  logic [OPN_W-1:0]      opened,
  output logic                  pick_found,
  output logic [PG_W-1:0]       pick_idx
);

  logic [COUNT_BITS-1:0] cnt_mem [MAX_PAGES];
  logic [MAX_PAGES-1:0]  zf_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;

  // Count memory: one write, one registered read; a zero-flagged entry reads 0
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    rd_cnt_r <= zf_r[rd_addr] ? '0 : cnt_mem[rd_addr];
  end

  // Zero flags, all set at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zf_r <= '1;
    end else if (wr_en) begin
      zf_r[wr_addr] <= (wr_data == '0);
    end
  end

  assign rd_cnt = rd_cnt_r;

  // Lowest opened page with a zero count
  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int i = MAX_PAGES - 1; i >= 0; i--) begin
      if (zf_r[i] && (OPN_W'(i) < opened)) begin
        pick_found = 1'b1;
        pick_idx   = PG_W'(i);
      end
    end
  end

endmodule

// ===== sv/refcounted_page_packet_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference counted page packet allocator
// Bump allocates packets on the current page, keeps a reference count per
// page and moves to a free or new page when the current one fills up.
//
//  Channel  Dir  Signals                            Payload
//  in       in   in_tvalid/in_tready                tuser mode, tdata size+page
//  out      out  out_tvalid/out_tready              tuser status, tdata result
//  cfg      in   cfg_wr_en/cfg_wr_data              max_packet_size
//
//  One item at a time. Allocate steps through check, count
//  read-modify-write, fill advance, threshold compare and output load;
//  retain/release skip the fill and threshold steps; requests rejected at the
//  check go straight to the output load. The shared adder and the registered count read set these steps.
//  Reset: zero flags cover the count memory, so no clearing pass is needed.
//  A stalled result holds the block in its output stage until taken.
// ----------------------------------------------------------------------------
`include "refcounted_page_packet_allocator_core_assert.svh"

module refcounted_page_packet_allocator_core
  import rppa_pkg::*;
#(
  parameter int MAX_PAGES    = MAX_PAGES_DEF,
  parameter int PAGE_SLOTS   = PAGE_SLOTS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_tuser,     // [1:0] mode
  input  logic [15:0]      in_tdata,     // [11:0] req_size, [15:12] page_index
  // result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [2:0]       out_tuser,    // [2:0] status
  output logic [47:0]      out_tdata,    // [3:0] out_page, [19:4] out_offset,
                                         // [31:20] out_length, [47:32] out_count
  // configuration
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data   // max_packet_size
);

  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int OPN_W  = $clog2(MAX_PAGES + 1);
  localparam int CMP_W  = (OPN_W > PAGE_W) ? OPN_W : PAGE_W;
  localparam int FILL_W = $clog2(MAX_PKT * PAGE_SLOTS + HEADER_BYTES + 1);
  localparam int AW     = (FILL_W > COUNT_BITS) ? FILL_W : COUNT_BITS;
  localparam int EXT_W  = (AW > OFF_W) ? AW : OFF_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RMW, S_FILL, S_THR, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [PAGE_W-1:0]   pg_r, pg_nxt;
  logic [FILL_W-1:0]   thr_r, thr_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [PG_W-1:0]     cur_r, cur_nxt;
  logic [OPN_W-1:0]    opened_r, opened_nxt;
  logic                pend_r, pend_nxt;
  logic [PG_W-1:0]     tp_r, tp_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [PAGE_W-1:0]   res_pg_r, res_pg_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic [LEN_W-1:0]    res_len_r, res_len_nxt;
  logic [OCNT_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [2:0]          out_tuser_r, out_tuser_nxt;
  logic [47:0]         out_tdata_r, out_tdata_nxt;

  logic [CFG_W-1:0]      mx;
  logic                  in_xfer;
  logic [CMP_W-1:0]      pg_ext;
  logic                  can_open;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  pick_found;
  logic [PG_W-1:0]       pick_idx;
  alu_op_t               alu_op;
  logic [AW-1:0]         alu_a, alu_b, alu_sum;
  logic                  alu_ge;

  // Effective packet size limit, clamped to 1..MAX_PKT
  always_comb begin
    if (cfg_r == '0) begin
      mx = CFG_W'(1);
    end else if (cfg_r > CFG_W'(MAX_PKT)) begin
      mx = CFG_W'(MAX_PKT);
    end else begin
      mx = cfg_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign pg_ext    = CMP_W'(pg_r);
  assign can_open  = (opened_r < OPN_W'(MAX_PAGES));
  assign new_cnt   = alu_sum[COUNT_BITS-1:0];

  rppa_alu #(.W(AW)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .sum    (alu_sum),
    .a_ge_b (alu_ge)
  );

  rppa_refmem #(.MAX_PAGES(MAX_PAGES), .COUNT_BITS(COUNT_BITS)) u_refmem (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (tp_nxt),
    .rd_cnt     (rd_cnt),
    .wr_en      (wr_en),
    .wr_addr    (tp_r),
    .wr_data    (new_cnt),
    .opened     (opened_r),
    .pick_found (pick_found),
    .pick_idx   (pick_idx)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    size_nxt       = size_r;
    pg_nxt         = pg_r;
    thr_nxt        = thr_r;
    fill_nxt       = fill_r;
    cur_nxt        = cur_r;
    opened_nxt     = opened_r;
    pend_nxt       = pend_r;
    tp_nxt         = tp_r;
    res_st_nxt     = res_st_r;
    res_pg_nxt     = res_pg_r;
    res_off_nxt    = res_off_r;
    res_len_nxt    = res_len_r;
    res_cnt_nxt    = res_cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tuser_nxt  = out_tuser_r;
    out_tdata_nxt  = out_tdata_r;
    wr_en          = 1'b0;
    alu_op         = ALU_ADD;
    alu_a          = AW'(rd_cnt);
    alu_b          = AW'(1);

    // output register drains on its own transfer
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt  = in_tuser;
          size_nxt  = in_tdata[11:0];
          pg_nxt    = in_tdata[15:12];
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        thr_nxt     = FILL_W'(mx) * FILL_W'(PAGE_SLOTS - 1) + FILL_W'(HEADER_BYTES);
        res_pg_nxt  = '0;
        res_off_nxt = '0;
        res_len_nxt = '0;
        res_cnt_nxt = '0;
        state_nxt   = S_DONE;
        case (mode_t'(mode_r))
          MODE_ALLOC: begin
            if (size_r == '0) begin
              res_st_nxt = ST_EMPTY;
            end else if ({1'b0, size_r} > mx) begin
              res_st_nxt = ST_OVERSIZE;
              res_pg_nxt = PAGE_W'(CMP_W'(cur_r));
            end else if (pend_r && pick_found) begin
              cur_nxt   = pick_idx;
              tp_nxt    = pick_idx;
              fill_nxt  = FILL_W'(HEADER_BYTES);
              pend_nxt  = 1'b0;
              state_nxt = S_RMW;
            end else if (pend_r && can_open) begin
              cur_nxt    = opened_r[PG_W-1:0];
              tp_nxt     = opened_r[PG_W-1:0];
              opened_nxt = opened_r + OPN_W'(1);
              fill_nxt   = FILL_W'(HEADER_BYTES);
              pend_nxt   = 1'b0;
              state_nxt  = S_RMW;
            end else if (pend_r) begin
              res_st_nxt = ST_NOPAGE;
              res_pg_nxt = PAGE_W'(CMP_W'(cur_r));
            end else begin
              tp_nxt    = cur_r;
              state_nxt = S_RMW;
            end
          end
          MODE_RETAIN, MODE_RELEASE: begin
            if (pg_ext >= CMP_W'(opened_r)) begin
              res_st_nxt = ST_NOPAGE;
              res_pg_nxt = pg_r;
            end else begin
              tp_nxt    = pg_ext[PG_W-1:0];
              state_nxt = S_RMW;
            end
          end
          default: begin
            res_st_nxt = ST_EMPTY;
          end
        endcase
      end

      // count read-modify-write through the shared adder
      S_RMW: begin
        res_pg_nxt = PAGE_W'(CMP_W'(tp_r));
        state_nxt  = S_DONE;
        if (mode_r == MODE_RELEASE) begin
          alu_op = ALU_SUB;
          if (rd_cnt == '0) begin
            res_st_nxt  = ST_UNDER;
            res_cnt_nxt = '0;
          end else begin
            wr_en       = 1'b1;
            res_st_nxt  = ST_OK;
            res_cnt_nxt = OCNT_W'(EXT_W'(new_cnt));
          end
        end else if (rd_cnt == '1) begin
          res_st_nxt  = ST_SAT;
          res_cnt_nxt = OCNT_W'(EXT_W'(rd_cnt));
        end else begin
          wr_en       = 1'b1;
          res_st_nxt  = ST_OK;
          res_cnt_nxt = OCNT_W'(EXT_W'(new_cnt));
          if (mode_r == MODE_ALLOC) begin
            res_off_nxt = OFF_W'(EXT_W'(fill_r));
            res_len_nxt = size_r;
            state_nxt   = S_FILL;
          end
        end
      end

      // advance fill pointer
      S_FILL: begin
        alu_op    = ALU_ADD;
        alu_a     = AW'(fill_r);
        alu_b     = AW'(size_r);
        fill_nxt  = alu_sum[FILL_W-1:0];
        state_nxt = S_THR;
      end

      // page full: move to a free page, open one, or mark pending
      S_THR: begin
        alu_op    = ALU_SUB;
        alu_a     = AW'(fill_r);
        alu_b     = AW'(thr_r);
        state_nxt = S_DONE;
        if (alu_ge) begin
          if (pick_found) begin
            cur_nxt  = pick_idx;
            fill_nxt = FILL_W'(HEADER_BYTES);
          end else if (can_open) begin
            cur_nxt    = opened_r[PG_W-1:0];
            opened_nxt = opened_r + OPN_W'(1);
            fill_nxt   = FILL_W'(HEADER_BYTES);
          end else begin
            pend_nxt = 1'b1;
          end
        end
      end

      // load the result once the output stage is free
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_st_r;
          out_tdata_nxt  = {res_cnt_r, res_len_r, res_off_r, res_pg_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_r        <= CFG_W'(MAX_PKT_RESET);
      fill_r       <= FILL_W'(HEADER_BYTES);
      cur_r        <= '0;
      opened_r     <= OPN_W'(1);
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      cur_r        <= cur_nxt;
      opened_r     <= opened_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    size_r      <= size_nxt;
    pg_r        <= pg_nxt;
    thr_r       <= thr_nxt;
    tp_r        <= tp_nxt;
    res_st_r    <= res_st_nxt;
    res_pg_r    <= res_pg_nxt;
    res_off_r   <= res_off_nxt;
    res_len_r   <= res_len_nxt;
    res_cnt_r   <= res_cnt_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  `RPPA_ASSERT_ALWAYS(a_opened_range, (opened_r != '0) && (opened_r <= OPN_W'(MAX_PAGES)))
  `RPPA_ASSERT_ALWAYS(a_cur_opened, OPN_W'(cur_r) < opened_r)
  `RPPA_ASSERT_IMPL(a_pend_all_open, pend_r, opened_r == OPN_W'(MAX_PAGES))
  `RPPA_ASSERT_NEXT(a_count_write_done, wr_en, (state_r == S_DONE) || (state_r == S_FILL))

endmodule
